[hw/rtl/lfu_key_cache_policy_core_macros.svh]
// Assertion macros used by the checker file.
// No dependencies; included by bare file name.
`ifndef LFU_KEY_CACHE_POLICY_CORE_MACROS_SVH
`define LFU_KEY_CACHE_POLICY_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LKCP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lkcp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LKCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lkcp assertion failed");

`endif

[hw/rtl/lkcp_pkg.sv]
// Types and constants for the LFU key cache.
// No dependencies; used by the core and its checker.
package lkcp_pkg;

  localparam int KEY_FIELD_W   = 40;
  localparam int COUNT_FIELD_W = 16;
  localparam int SLOT_FIELD_W  = 4;
  localparam int STATUS_W      = 2;

  localparam logic CMD_PRELOAD = 1'b0;
  localparam logic CMD_ACCESS  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_HIT     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FILL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REPLACE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd3;

  typedef struct packed {
    logic                     cmd;
    logic [KEY_FIELD_W-1:0]   key;
    logic [COUNT_FIELD_W-1:0] preload_count;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [SLOT_FIELD_W-1:0]  slot;
    logic [KEY_FIELD_W-1:0]   victim_key;
    logic [COUNT_FIELD_W-1:0] new_count;
  } out_item_t;

endpackage

[hw/rtl/lfu_key_cache_policy_core.sv]
// The block takes no new item until the current one is decided; a single compare unit walks the
// key/count memory one entry per cycle, then the decide state decides and writes back.
// The result register lets the next item be taken while a result waits.
// Reset (rst_n, synchronous): store empty (fill count zero), sequencer idle, no result.
module lfu_key_cache_policy_core #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BYTES  = 5,
  parameter int COUNT_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lkcp_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lkcp_pkg::out_item_t  out_data
);

  localparam int KEY_W  = KEY_BYTES * 8;
  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int FILL_W = $clog2(ENTRIES + 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [FILL_W-1:0]     FILL_FULL = FILL_W'(ENTRIES);
  localparam logic [FILL_W-1:0]     SCAN_END  = FILL_W'(ENTRIES);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  // key / count store
  logic [KEY_W-1:0]      key_mem [ENTRIES];
  logic [COUNT_BITS-1:0] cnt_mem [ENTRIES];
  logic [KEY_W-1:0]      rd_key_r;
  logic [COUNT_BITS-1:0] rd_cnt_r;

  logic [1:0]            state_r, state_nxt;
  logic [FILL_W-1:0]     scan_r, scan_nxt;
  logic [FILL_W-1:0]     fill_r, fill_nxt;
  logic                  cmd_r;
  logic [KEY_W-1:0]      key_r;
  logic [COUNT_BITS-1:0] pc_r;
  logic                  hit_r, hit_nxt;
  logic [IDX_W-1:0]      hit_idx_r, hit_idx_nxt;
  logic [COUNT_BITS-1:0] hit_cnt_r, hit_cnt_nxt;
  logic [IDX_W-1:0]      best_idx_r, best_idx_nxt;
  logic [COUNT_BITS-1:0] best_cnt_r, best_cnt_nxt;
  logic [KEY_W-1:0]      best_key_r, best_key_nxt;
  logic                  out_valid_r, out_valid_nxt;
  lkcp_pkg::out_item_t   out_data_r, out_data_nxt;

  logic [63:0]           key_in_ext;
  logic [31:0]           pc_in_ext;
  logic [FILL_W-1:0]     proc_pos;
  logic [IDX_W-1:0]      proc_idx;
  logic                  proc_en;
  logic                  better;
  logic                  out_free;
  logic                  full;

  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [KEY_W-1:0]      wr_key;
  logic [COUNT_BITS-1:0] wr_cnt;
  logic [1:0]            res_status;
  logic [IDX_W-1:0]      res_slot;
  logic [KEY_W-1:0]      res_victim;
  logic [COUNT_BITS-1:0] res_cnt;
  logic                  fill_inc;
  logic [7:0]            slot_ext;
  logic [63:0]           victim_ext;
  logic [31:0]           cnt_ext;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;
  assign full      = (fill_r == FILL_FULL);

  assign key_in_ext = 64'(in_data.key);
  assign pc_in_ext  = 32'(in_data.preload_count);

  // scan step c reads entry c and evaluates entry c-1
  assign proc_pos = scan_r - FILL_W'(1);
  assign proc_idx = proc_pos[IDX_W-1:0];
  assign proc_en  = (state_r == S_SCAN) && (scan_r != '0) && (proc_pos < fill_r);
  assign better   = (proc_pos == '0) || (rd_cnt_r < best_cnt_r) ||
                    ((rd_cnt_r == best_cnt_r) && (rd_key_r < best_key_r));

  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = fill_r[IDX_W-1:0];
    wr_key     = key_r;
    wr_cnt     = COUNT_BITS'(1);
    res_status = lkcp_pkg::ST_FILL;
    res_slot   = fill_r[IDX_W-1:0];
    res_victim = '0;
    res_cnt    = COUNT_BITS'(1);
    fill_inc   = 1'b0;
    if (cmd_r == lkcp_pkg::CMD_PRELOAD) begin
      priority if (hit_r) begin
        res_status = lkcp_pkg::ST_IGNORED;
        res_slot   = hit_idx_r;
        res_cnt    = hit_cnt_r;
      end else if (full) begin
        res_status = lkcp_pkg::ST_IGNORED;
        res_slot   = '0;
        res_cnt    = '0;
      end else begin
        wr_en    = 1'b1;
        wr_cnt   = pc_r;
        res_cnt  = pc_r;
        fill_inc = 1'b1;
      end
    end else begin
      priority if (hit_r) begin
        wr_en      = 1'b1;
        wr_addr    = hit_idx_r;
        wr_key     = key_r;
        wr_cnt     = (hit_cnt_r == COUNT_MAX) ? hit_cnt_r : hit_cnt_r + COUNT_BITS'(1);
        res_status = lkcp_pkg::ST_HIT;
        res_slot   = hit_idx_r;
        res_cnt    = wr_cnt;
      end else if (!full) begin
        wr_en    = 1'b1;
        fill_inc = 1'b1;
      end else begin
        wr_en      = 1'b1;
        wr_addr    = best_idx_r;
        res_status = lkcp_pkg::ST_REPLACE;
        res_slot   = best_idx_r;
        res_victim = best_key_r;
      end
    end
  end

  assign slot_ext   = 8'(res_slot);
  assign victim_ext = 64'(res_victim);
  assign cnt_ext    = 32'(res_cnt);

  always_comb begin
    state_nxt     = state_r;
    scan_nxt      = scan_r;
    fill_nxt      = fill_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_cnt_nxt   = hit_cnt_r;
    best_idx_nxt  = best_idx_r;
    best_cnt_nxt  = best_cnt_r;
    best_key_nxt  = best_key_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SCAN;
          scan_nxt  = '0;
          hit_nxt   = 1'b0;
        end
      end
      S_SCAN: begin
        if (proc_en && !hit_r && (rd_key_r == key_r)) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = proc_idx;
          hit_cnt_nxt = rd_cnt_r;
        end
        if (proc_en && better) begin
          best_idx_nxt = proc_idx;
          best_cnt_nxt = rd_cnt_r;
          best_key_nxt = rd_key_r;
        end
        scan_nxt = scan_r + FILL_W'(1);
        if (scan_r == SCAN_END) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (out_free) begin
          state_nxt               = S_IDLE;
          out_valid_nxt           = 1'b1;
          out_data_nxt.status     = res_status;
          out_data_nxt.slot       = slot_ext[lkcp_pkg::SLOT_FIELD_W-1:0];
          out_data_nxt.victim_key = victim_ext[lkcp_pkg::KEY_FIELD_W-1:0];
          out_data_nxt.new_count  = cnt_ext[lkcp_pkg::COUNT_FIELD_W-1:0];
          if (fill_inc) begin
            fill_nxt = fill_r + FILL_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
      scan_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      hit_r       <= hit_nxt;
      scan_r      <= scan_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      cmd_r <= in_data.cmd;
      key_r <= key_in_ext[KEY_W-1:0];
      pc_r  <= pc_in_ext[COUNT_BITS-1:0];
    end
    hit_idx_r  <= hit_idx_nxt;
    hit_cnt_r  <= hit_cnt_nxt;
    best_idx_r <= best_idx_nxt;
    best_cnt_r <= best_cnt_nxt;
    best_key_r <= best_key_nxt;
    out_data_r <= out_data_nxt;
  end

  // single read port driven by the scan counter, single write port at decide
  always_ff @(posedge clk) begin
    rd_key_r <= key_mem[scan_r[IDX_W-1:0]];
    rd_cnt_r <= cnt_mem[scan_r[IDX_W-1:0]];
    if (state_r == S_DECIDE && out_free && wr_en) begin
      key_mem[wr_addr] <= wr_key;
      cnt_mem[wr_addr] <= wr_cnt;
    end
  end

endmodule

[hw/rtl/lkcp_checker.sv]
// Port-level checker for lfu_key_cache_policy_core, bound into the core module.
// Depends on lkcp_pkg and lfu_key_cache_policy_core_macros.svh.
`include "lfu_key_cache_policy_core_macros.svh"

module lkcp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input lkcp_pkg::out_item_t out_data
);

  // a result that is not taken stays put
  `LKCP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // the scan keeps the block busy after an item is accepted
  `LKCP_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `LKCP_ASSERT_NEXT(a_busy_two_cycles, clk, rst_n, in_valid && in_ready, ##1 !in_ready)

  // only a replacement reports an evicted key
  `LKCP_ASSERT_IMPL(a_victim_zero, clk, rst_n, out_valid && (out_data.status != lkcp_pkg::ST_REPLACE), out_data.victim_key == '0)

endmodule

bind lfu_key_cache_policy_core lkcp_checker u_lkcp_checker (.*);

[dv/lfu_key_cache_policy_core_tb.sv]
// Self-checking bench for lfu_key_cache_policy_core: a directed table, then random bursts,
// scored against typed table expectations or an LFU cache model kept inside the bench.
// Depends on lkcp_pkg (item types, command and status codes) and the core RTL.
module lfu_key_cache_policy_core_tb;

  localparam int CACHE_SLOTS  = 16;
  localparam int RANDOM_ITEMS = 1400;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_LIMIT   = 2000;
  localparam int POOL_SIZE    = 24;

  typedef logic [lkcp_pkg::KEY_FIELD_W-1:0]   key_t;
  typedef logic [lkcp_pkg::COUNT_FIELD_W-1:0] count_t;

  typedef struct {
    lkcp_pkg::in_item_t  stim;
    bit                  typed;
    lkcp_pkg::out_item_t want;
  } table_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  lkcp_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  lkcp_pkg::out_item_t out_data;

  // cache contents as the bench expects them
  key_t        lfu_key   [CACHE_SLOTS];
  count_t      lfu_count [CACHE_SLOTS];
  bit          lfu_valid [CACHE_SLOTS];
  int unsigned lfu_fill;

  lkcp_pkg::out_item_t pending_results [$];
  table_row_t          directed_rows [$];
  key_t                key_pool [POOL_SIZE];
  lkcp_pkg::out_item_t oldest_result;

  int unsigned error_count;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned idle_cycles;
  int unsigned burst_left;
  int unsigned status_seen [4];
  int unsigned rx_cycle;
  int unsigned rx_hold;

  lfu_key_cache_policy_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  // One step of the LFU cache: returns the result and updates the bench copy.
  function automatic lkcp_pkg::out_item_t cache_step(input lkcp_pkg::in_item_t it);
    lkcp_pkg::out_item_t r;
    int                  hit;
    int                  best;
    int                  s;
    r   = '0;
    hit = -1;
    for (s = 0; s < CACHE_SLOTS; s++) begin
      if (hit < 0 && lfu_valid[s] && lfu_key[s] == it.key) hit = s;
    end
    if (it.cmd == lkcp_pkg::CMD_PRELOAD) begin
      if (hit >= 0) begin
        r.status    = lkcp_pkg::ST_IGNORED;
        r.slot      = lkcp_pkg::SLOT_FIELD_W'(hit);
        r.new_count = lfu_count[hit];
      end else if (lfu_fill >= CACHE_SLOTS) begin
        r.status = lkcp_pkg::ST_IGNORED;  // full store: slot and count read as zero
      end else begin
        r.status            = lkcp_pkg::ST_FILL;
        r.slot              = lkcp_pkg::SLOT_FIELD_W'(lfu_fill);
        r.new_count         = it.preload_count;
        lfu_key[lfu_fill]   = it.key;
        lfu_count[lfu_fill] = it.preload_count;
        lfu_valid[lfu_fill] = 1'b1;
        lfu_fill++;
      end
    end else if (hit >= 0) begin
      if (lfu_count[hit] != '1) lfu_count[hit]++;
      r.status    = lkcp_pkg::ST_HIT;
      r.slot      = lkcp_pkg::SLOT_FIELD_W'(hit);
      r.new_count = lfu_count[hit];
    end else if (lfu_fill < CACHE_SLOTS) begin
      r.status            = lkcp_pkg::ST_FILL;
      r.slot              = lkcp_pkg::SLOT_FIELD_W'(lfu_fill);
      r.new_count         = count_t'(1);
      lfu_key[lfu_fill]   = it.key;
      lfu_count[lfu_fill] = count_t'(1);
      lfu_valid[lfu_fill] = 1'b1;
      lfu_fill++;
    end else begin
      // least count wins, smallest key among equal counts
      best = 0;
      for (s = 1; s < CACHE_SLOTS; s++) begin
        if (lfu_count[s] < lfu_count[best] ||
            (lfu_count[s] == lfu_count[best] && lfu_key[s] < lfu_key[best])) best = s;
      end
      r.status        = lkcp_pkg::ST_REPLACE;
      r.slot          = lkcp_pkg::SLOT_FIELD_W'(best);
      r.victim_key    = lfu_key[best];
      r.new_count     = count_t'(1);
      lfu_key[best]   = it.key;
      lfu_count[best] = count_t'(1);
    end
    return r;
  endfunction

  function automatic void add_row(input logic cmd, input key_t key, input count_t pc,
                                  input bit typed,
                                  input logic [lkcp_pkg::STATUS_W-1:0] st,
                                  input int sl, input count_t nc);
    table_row_t row;
    row.stim.cmd           = cmd;
    row.stim.key           = key;
    row.stim.preload_count = pc;
    row.typed              = typed;
    row.want               = '0;
    row.want.status        = st;
    row.want.slot          = lkcp_pkg::SLOT_FIELD_W'(sl);
    row.want.new_count     = nc;
    directed_rows.push_back(row);
  endfunction

  // Hold the item until accepted, then queue what the cache should answer.
  task automatic drive_item(input lkcp_pkg::in_item_t stim, input bit typed,
                            input lkcp_pkg::out_item_t want);
    lkcp_pkg::out_item_t predicted;
    in_valid <= 1'b1;
    in_data  <= stim;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = cache_step(stim);
    pending_results.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  // Sender bursts: random-length runs of back-to-back items, then a random gap.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 1) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 10);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Receiver: steps through four modes in turn (open, coin flip, long holds, mostly open).
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else begin
      case ((rx_cycle / 256) % 4)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        2: begin
          out_ready <= ~out_ready;
          rx_hold   <= $urandom_range(0, 30);
        end
        default: out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      status_seen[out_data.status]++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: status %0d slot %0d key %h count %0d",
               out_data.status, out_data.slot, out_data.victim_key, out_data.new_count);
        error_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_data.status !== oldest_result.status) begin
          $error("status: expected %0d, got %0d", oldest_result.status, out_data.status);
          error_count++;
        end
        if (out_data.slot !== oldest_result.slot) begin
          $error("slot: expected %0d, got %0d", oldest_result.slot, out_data.slot);
          error_count++;
        end
        if (out_data.victim_key !== oldest_result.victim_key) begin
          $error("victim_key: expected %h, got %h", oldest_result.victim_key,
                 out_data.victim_key);
          error_count++;
        end
        if (out_data.new_count !== oldest_result.new_count) begin
          $error("new_count: expected %0d, got %0d", oldest_result.new_count,
                 out_data.new_count);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: %0d cycles with no item moving", idle_cycles);
      $display("lfu_key_cache_policy_core regression: fail");
      $finish;
    end
  end

  initial begin
    lkcp_pkg::in_item_t stim;
    key_t               last_key;
    int unsigned        useful;
    int unsigned        pick;
    int                 i;
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b0;
    burst_left = 1;

    // Directed table; typed expectations only where they are obvious.
    add_row(lkcp_pkg::CMD_ACCESS,  40'h0,          16'hFFFF, 1, lkcp_pkg::ST_FILL,
            0, 16'd1);   // zero key
    add_row(lkcp_pkg::CMD_PRELOAD, 40'hFFFFFFFFFF, 16'hFFFF, 1, lkcp_pkg::ST_FILL,
            1, 16'hFFFF);
    add_row(lkcp_pkg::CMD_ACCESS,  40'hFFFFFFFFFF, 16'h0,    1, lkcp_pkg::ST_HIT,
            1, 16'hFFFF); // saturated
    add_row(lkcp_pkg::CMD_PRELOAD, 40'h0,          16'h7,    1, lkcp_pkg::ST_IGNORED,
            0, 16'd1);   // present
    add_row(lkcp_pkg::CMD_PRELOAD, 40'h6162006364, 16'h0,    1, lkcp_pkg::ST_FILL,
            2, 16'd0);   // "ab\0cd"
    add_row(lkcp_pkg::CMD_ACCESS,  40'h6162000000, 16'h0,    1, lkcp_pkg::ST_FILL,
            3, 16'd1);   // "ab"
    add_row(lkcp_pkg::CMD_ACCESS,  40'h6162006364, 16'h0,    1, lkcp_pkg::ST_HIT,
            2, 16'd1);
    add_row(lkcp_pkg::CMD_PRELOAD, 40'h7A7A000000, 16'hFFFE, 1, lkcp_pkg::ST_FILL,
            4, 16'hFFFE);
    add_row(lkcp_pkg::CMD_ACCESS,  40'h7A7A000000, 16'h0,    1, lkcp_pkg::ST_HIT,
            4, 16'hFFFF);
    add_row(lkcp_pkg::CMD_ACCESS,  40'h7A7A000000, 16'h0,    1, lkcp_pkg::ST_HIT,
            4, 16'hFFFF);
    for (i = 5; i < CACHE_SLOTS; i++) begin
      add_row((i % 2 == 1) ? lkcp_pkg::CMD_PRELOAD : lkcp_pkg::CMD_ACCESS,
              {8'h6B, 8'h30 + 8'(i), 24'h0},
              (i % 3 == 0) ? 16'h0 : count_t'(i * 1000), 0, lkcp_pkg::ST_HIT, 0, 16'd0);
    end
    add_row(lkcp_pkg::CMD_PRELOAD, 40'h6F70000000, 16'h55,   1, lkcp_pkg::ST_IGNORED,
            0, 16'd0);   // store full
    // evictions: two zero-count entries, tie settled by the smaller key
    add_row(lkcp_pkg::CMD_ACCESS,  40'h6E65770000, 16'h0,    0, lkcp_pkg::ST_HIT,
            0, 16'd0);
    add_row(lkcp_pkg::CMD_ACCESS,  40'h6E65770000, 16'h0,    0, lkcp_pkg::ST_HIT,
            0, 16'd0);
    add_row(lkcp_pkg::CMD_ACCESS,  40'h0000000001, 16'h0,    0, lkcp_pkg::ST_HIT,
            0, 16'd0);

    // pool: text-like and random keys, each followed by a neighbor one LSB apart for close ties
    for (i = 0; i < POOL_SIZE; i++) begin
      if (i % 2 == 1) key_pool[i] = key_pool[i-1] ^ key_t'(1);
      else if (i % 4 == 0) key_pool[i] = {8'h61 + 8'(i), 8'h6B, 8'h00, 8'h79, 8'h00};
      else key_pool[i] = key_t'({$urandom, $urandom});
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      drive_item(directed_rows[r].stim, directed_rows[r].typed, directed_rows[r].want);
      pace_sender();
    end

    useful   = 0;
    last_key = '0;
    while (useful < RANDOM_ITEMS) begin
      pick               = $urandom_range(0, 99);
      stim.cmd           = (pick < 20) ? lkcp_pkg::CMD_PRELOAD : lkcp_pkg::CMD_ACCESS;
      stim.preload_count = count_t'($urandom);
      case ($urandom_range(0, 9))
        0, 1:    stim.key = key_t'({$urandom, $urandom});
        2, 3:    stim.key = last_key;
        default: stim.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      endcase
      drive_item(stim, 0, '0);
      last_key = stim.key;
      useful++;
      pace_sender();
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d items (%0d from the table), checked %0d results", items_sent,
             directed_rows.size(), results_seen);
    $display("by status: %0d hits, %0d fills, %0d evictions, %0d ignored preloads",
             status_seen[lkcp_pkg::ST_HIT], status_seen[lkcp_pkg::ST_FILL],
             status_seen[lkcp_pkg::ST_REPLACE], status_seen[lkcp_pkg::ST_IGNORED]);
    if (error_count == 0) begin
      $display("lfu_key_cache_policy_core regression: pass");
    end else begin
      $display("lfu_key_cache_policy_core regression: fail");
    end
    $finish;
  end

endmodule
